FILE: design/csl_pkg.sv
// Shared types, constants and scan functions of the coordinate sorted list.
package csl_pkg;

    localparam int CAPACITY  = 64;
    localparam int GRID_SIZE = 1024;
    localparam int ID_W      = 16;
    localparam int KEY_W     = 10;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam logic [KEY_W-1:0] KEY_MAX = KEY_W'(GRID_SIZE - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;

    // Status codes.
    localparam logic [1:0] STS_DONE      = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;

    typedef logic [CAPACITY-1:0] t_vec;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [ID_W-1:0]  entry_id;
        logic [KEY_W-1:0] pos_x;
        logic [KEY_W-1:0] pos_y;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] rank;
        logic [CNT_W-1:0] entry_count;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_slot;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_req;

    // Comparison results of one cell against the pending request.
    typedef struct packed {
        logic occ;
        logic match;
        logic gt;
        logic ge;
        logic le;
    } t_cell_flags;

    // The same results gathered across the whole chain.
    typedef struct packed {
        t_vec occ;
        t_vec match;
        t_vec gt;
        t_vec ge;
        t_vec le;
    } t_scan_flags;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_LEFT,
        CMD_RIGHT
    } t_cell_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } t_state;

    // Inclusive prefix OR towards higher indexes, built as a log-depth network.
    function automatic t_vec prefix_or(input t_vec v);
        t_vec r;
        r = v;
        for (int lvl = 0; lvl < IDX_W; lvl++) begin
            r = r | (r << (1 << lvl));
        end
        return r;
    endfunction

    // Inclusive suffix OR towards lower indexes.
    function automatic t_vec suffix_or(input t_vec v);
        t_vec r;
        r = v;
        for (int lvl = 0; lvl < IDX_W; lvl++) begin
            r = r | (r >> (1 << lvl));
        end
        return r;
    endfunction

    // Index of the set bit of a one-hot vector; zero when none is set.
    function automatic logic [IDX_W-1:0] onehot_index(input t_vec v);
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] ival;
        idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            ival = IDX_W'(i);
            for (int b = 0; b < IDX_W; b++) begin
                idx[b] = idx[b] | (v[i] & ival[b]);
            end
        end
        return idx;
    endfunction

endpackage

FILE: design/csl_cell.sv
// One slot of the sorted list: holds an entry, compares it and shifts it.
module csl_cell (
    input  logic                          i_clk,
    input  logic [csl_pkg::IDX_W-1:0]     i_index,
    input  logic [csl_pkg::CNT_W-1:0]     i_count,
    input  logic                          i_flag_en,
    input  logic [csl_pkg::ID_W-1:0]      i_req_id,
    input  logic [csl_pkg::KEY_W-1:0]     i_req_key,
    input  csl_pkg::t_cell_cmd            i_cmd,
    input  csl_pkg::t_slot                i_new,
    input  csl_pkg::t_slot                i_left,
    input  csl_pkg::t_slot                i_right,
    output csl_pkg::t_slot                o_slot,
    output csl_pkg::t_cell_flags          o_flags
);

    csl_pkg::t_slot       r_slot;
    csl_pkg::t_slot       n_slot;
    csl_pkg::t_cell_flags r_flags;
    csl_pkg::t_cell_flags n_flags;

    always_comb begin
        n_flags.occ   = csl_pkg::CNT_W'(i_index) < i_count;
        n_flags.match = n_flags.occ && (r_slot.id == i_req_id);
        n_flags.gt    = r_slot.key >  i_req_key;
        n_flags.ge    = r_slot.key >= i_req_key;
        n_flags.le    = r_slot.key <= i_req_key;
    end

    always_comb begin
        unique case (i_cmd)
            csl_pkg::CMD_HOLD:  n_slot = r_slot;
            csl_pkg::CMD_LOAD:  n_slot = i_new;
            csl_pkg::CMD_LEFT:  n_slot = i_left;
            csl_pkg::CMD_RIGHT: n_slot = i_right;
            default:            n_slot = r_slot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (i_flag_en) begin
            r_flags <= n_flags;
        end
    end

    assign o_slot  = r_slot;
    assign o_flags = r_flags;

endmodule

FILE: design/csl_scan.sv
// Turns the chain's comparison flags into per-cell shift commands and the result.
module csl_scan (
    input  logic                                   i_go,
    input  logic [1:0]                             i_req_type,
    input  logic [csl_pkg::CNT_W-1:0]              i_count,
    input  csl_pkg::t_scan_flags                   i_flags,
    output csl_pkg::t_cell_cmd [csl_pkg::CAPACITY-1:0] o_cmd,
    output csl_pkg::t_out_item                     o_result
);

    csl_pkg::t_vec w_m_incl;
    csl_pkg::t_vec w_m_first;
    logic          w_found;
    logic          w_full;

    csl_pkg::t_vec w_aap;
    csl_pkg::t_vec w_dest_ins;

    csl_pkg::t_vec w_region_b;
    csl_pkg::t_vec w_dest_b;
    logic          w_back;

    csl_pkg::t_vec w_region_f;
    csl_pkg::t_vec w_dest_f;

    csl_pkg::t_vec w_dest_upd;

    always_comb begin
        w_m_incl  = csl_pkg::prefix_or(i_flags.match);
        w_m_first = w_m_incl & ~(w_m_incl << 1);
        w_found   = w_m_incl[csl_pkg::CAPACITY-1];
        w_full    = (i_count == csl_pkg::CNT_FULL);

        // Insert goes in front of the first larger key, or after the last entry.
        w_aap      = csl_pkg::prefix_or(i_flags.gt & i_flags.occ) | ~i_flags.occ;
        w_dest_ins = w_aap & ~(w_aap << 1);

        // Backward move: cells from just after the nearest smaller-or-equal
        // predecessor up to the updated entry.
        w_region_b = ~csl_pkg::suffix_or(i_flags.le & ~w_m_incl)
                     & (~w_m_incl | w_m_first);
        w_dest_b   = w_region_b & ~(w_region_b << 1);
        w_back     = |(w_region_b & (w_m_first >> 1));

        // Forward move: cells from the updated entry up to just before the
        // nearest larger-or-equal successor, or to the last entry.
        w_region_f = w_m_incl & i_flags.occ
                     & ~csl_pkg::prefix_or(i_flags.ge & i_flags.occ & w_m_incl & ~w_m_first);
        w_dest_f   = w_region_f & ~(w_region_f >> 1);

        w_dest_upd = w_back ? w_dest_b : w_dest_f;
    end

    always_comb begin
        for (int i = 0; i < csl_pkg::CAPACITY; i++) begin
            o_cmd[i] = csl_pkg::CMD_HOLD;
        end
        o_result.status      = csl_pkg::STS_DONE;
        o_result.rank        = '0;
        o_result.entry_count = i_count;

        unique case (i_req_type)
            csl_pkg::REQ_INSERT: begin
                if (w_full) begin
                    o_result.status = csl_pkg::STS_FULL;
                end else begin
                    o_result.rank        = csl_pkg::onehot_index(w_dest_ins);
                    o_result.entry_count = i_count + csl_pkg::CNT_W'(1);
                    for (int i = 0; i < csl_pkg::CAPACITY; i++) begin
                        if (i_go && w_dest_ins[i]) begin
                            o_cmd[i] = csl_pkg::CMD_LOAD;
                        end else if (i_go && w_aap[i]) begin
                            o_cmd[i] = csl_pkg::CMD_LEFT;
                        end
                    end
                end
            end
            csl_pkg::REQ_REMOVE: begin
                if (!w_found) begin
                    o_result.status = csl_pkg::STS_NOT_FOUND;
                end else begin
                    o_result.entry_count = i_count - csl_pkg::CNT_W'(1);
                    for (int i = 0; i < csl_pkg::CAPACITY; i++) begin
                        if (i_go && w_m_incl[i]) begin
                            o_cmd[i] = csl_pkg::CMD_RIGHT;
                        end
                    end
                end
            end
            csl_pkg::REQ_UPDATE: begin
                if (!w_found) begin
                    o_result.status = csl_pkg::STS_NOT_FOUND;
                end else begin
                    o_result.rank = csl_pkg::onehot_index(w_dest_upd);
                    for (int i = 0; i < csl_pkg::CAPACITY; i++) begin
                        if (i_go && w_dest_upd[i]) begin
                            o_cmd[i] = csl_pkg::CMD_LOAD;
                        end else if (i_go && w_back && w_region_b[i]) begin
                            o_cmd[i] = csl_pkg::CMD_LEFT;
                        end else if (i_go && !w_back && w_region_f[i]) begin
                            o_cmd[i] = csl_pkg::CMD_RIGHT;
                        end
                    end
                end
            end
            default: begin
                o_result.status = csl_pkg::STS_DONE;
            end
        endcase
    end

endmodule

FILE: design/coordinate_sorted_list.sv
// Top level of the coordinate sorted list: control, chain of slot cells and result register.
//
// The block does not accept a new item until it is through with the last one. In the
// cycle of acceptance every slot cell compares its entry with the item's id and key at
// once; in the apply state log-depth prefix networks over those registered flags pick the
// destination slot, and the whole chain shifts by at most one place while the result is
// loaded into the output register. The apply state waits only while an earlier result
// is still held in the output register and stalled. Slot contents are not cleared at
// reset, and no clearing pass runs: only slots below the entry count are ever used.
module coordinate_sorted_list (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  csl_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output csl_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    csl_pkg::t_state    r_state;
    csl_pkg::t_state    n_state;
    logic               r_axis;
    logic [csl_pkg::CNT_W-1:0] r_count;
    csl_pkg::t_req      r_req;
    logic               r_out_valid;
    csl_pkg::t_out_item r_out_data;

    logic               w_accept;
    logic               w_go;
    logic [csl_pkg::KEY_W-1:0] w_raw_key;
    logic [csl_pkg::KEY_W-1:0] w_in_key;
    csl_pkg::t_slot     w_new;
    csl_pkg::t_slot     w_slot [csl_pkg::CAPACITY];
    csl_pkg::t_cell_flags w_cflags [csl_pkg::CAPACITY];
    csl_pkg::t_scan_flags w_flags;
    csl_pkg::t_cell_cmd [csl_pkg::CAPACITY-1:0] w_cmd;
    csl_pkg::t_out_item w_result;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            csl_pkg::ST_IDLE:  if (i_in_valid) n_state = csl_pkg::ST_APPLY;
            csl_pkg::ST_APPLY: if (w_go) n_state = csl_pkg::ST_IDLE;
            default:           n_state = csl_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall = 1'b1;
        w_go       = 1'b0;
        unique case (r_state)
            csl_pkg::ST_IDLE:  o_in_stall = 1'b0;
            csl_pkg::ST_APPLY: w_go = !r_out_valid || !i_out_stall;
            default:           o_in_stall = 1'b1;
        endcase
    end

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_raw_key = r_axis ? i_in_data.pos_y : i_in_data.pos_x;
        w_in_key  = (w_raw_key > csl_pkg::KEY_MAX) ? csl_pkg::KEY_MAX : w_raw_key;
        w_new.id  = r_req.id;
        w_new.key = r_req.key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csl_pkg::ST_IDLE;
            r_axis      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_axis <= i_cfg_data;
            end
            if (w_go) begin
                r_count     <= w_result.entry_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.req_type <= i_in_data.req_type;
            r_req.id       <= i_in_data.entry_id;
            r_req.key      <= w_in_key;
        end
        if (w_go) begin
            r_out_data <= w_result;
        end
    end

    for (genvar g = 0; g < csl_pkg::CAPACITY; g++) begin : g_cell
        csl_cell u_cell (
            .i_clk     (i_clk),
            .i_index   (csl_pkg::IDX_W'(g)),
            .i_count   (r_count),
            .i_flag_en (w_accept),
            .i_req_id  (i_in_data.entry_id),
            .i_req_key (w_in_key),
            .i_cmd     (w_cmd[g]),
            .i_new     (w_new),
            .i_left    ((g == 0) ? w_new : w_slot[(g == 0) ? 0 : g - 1]),
            .i_right   ((g == csl_pkg::CAPACITY - 1) ? w_new
                        : w_slot[(g == csl_pkg::CAPACITY - 1) ? g : g + 1]),
            .o_slot    (w_slot[g]),
            .o_flags   (w_cflags[g])
        );

        assign w_flags.occ[g]   = w_cflags[g].occ;
        assign w_flags.match[g] = w_cflags[g].match;
        assign w_flags.gt[g]    = w_cflags[g].gt;
        assign w_flags.ge[g]    = w_cflags[g].ge;
        assign w_flags.le[g]    = w_cflags[g].le;
    end

    csl_scan u_scan (
        .i_go       (w_go),
        .i_req_type (r_req.req_type),
        .i_count    (r_count),
        .i_flags    (w_flags),
        .o_cmd      (w_cmd),
        .o_result   (w_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The entry count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= csl_pkg::CNT_FULL)
        else $error("entry count beyond capacity");

    // The count changes only in an apply cycle.
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(w_go) |-> $stable(r_count))
        else $error("entry count changed outside an apply cycle");

    // The count moves by at most one per item.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count))
                        || (r_count == $past(r_count) + csl_pkg::CNT_W'(1))
                        || (r_count == $past(r_count) - csl_pkg::CNT_W'(1)))
        else $error("entry count moved by more than one");

    // A new result appears only after an apply cycle.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_valid) |-> $past(w_go))
        else $error("result produced without an apply cycle");

endmodule
